>>> rtl/core/pnre_pkg.sv
`timescale 1ns / 1ps
package pnre_pkg;

    localparam int TableEntries = 256;
    localparam int IdxW = $clog2(TableEntries);
    localparam int CntW = $clog2(TableEntries + 1);

    localparam logic [15:0] EthTypeIpv4 = 16'h0800;
    localparam logic [7:0]  ProtoTcp = 8'd6;
    localparam logic [7:0]  ProtoUdp = 8'd17;
    localparam int FlagFin = 0;
    localparam int FlagSyn = 1;
    localparam int FlagAck = 4;

    localparam logic [1:0] CfgBridgeIp = 2'd0;
    localparam logic [1:0] CfgProxyPort = 2'd1;
    localparam logic [1:0] CfgDnsProxyPort = 2'd2;
    localparam logic [1:0] CfgDnsCapturePort = 2'd3;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_READ,
        ST_WRITE,
        ST_OUT
    } state_t;

    // What the header decode asks of the tables.
    typedef enum logic [1:0] {
        OP_NONE,
        OP_LOOKUP,
        OP_INSERT
    } op_t;

    typedef struct packed {
        logic load;
        logic scan_start;
        logic scan_step;
        logic rd_origin;
        logic wr_apply;
        logic out_load;
    } pnre_cmd_t;

    typedef struct packed {
        op_t  op;
        logic scan_done;
    } pnre_sts_t;

    // One RFC 1624 update of a 16 bit word, end-around carry folded twice.
    function automatic logic [15:0] csum_rep16(input logic [15:0] hc,
                                               input logic [15:0] from,
                                               input logic [15:0] to);
        logic [17:0] s;
        logic [16:0] f;
        begin
            s = {2'b0, ~hc} + {2'b0, ~from} + {2'b0, to};
            f = {1'b0, s[15:0]} + {15'b0, s[17:16]};
            f = {1'b0, f[15:0]} + {16'b0, f[16]};
            csum_rep16 = ~f[15:0];
        end
    endfunction

    function automatic logic [15:0] csum_rep32(input logic [15:0] hc,
                                               input logic [31:0] from,
                                               input logic [31:0] to);
        logic [18:0] s;
        logic [16:0] f;
        begin
            s = {3'b0, ~hc} + {3'b0, ~from[31:16]} + {3'b0, ~from[15:0]}
                + {3'b0, to[31:16]} + {3'b0, to[15:0]};
            f = {1'b0, s[15:0]} + {14'b0, s[18:16]};
            f = {1'b0, f[15:0]} + {16'b0, f[16]};
            csum_rep32 = ~f[15:0];
        end
    endfunction

endpackage

>>> rtl/core/pnre_ctrl.sv
`timescale 1ns / 1ps
module pnre_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_fire,
    input  logic                 out_free,
    input  pnre_pkg::pnre_sts_t  sts,
    output pnre_pkg::pnre_cmd_t  cmd,
    output logic                 busy
);

    pnre_pkg::state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= pnre_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd = '0;
        busy = 1'b1;
        unique case (state_reg)
            pnre_pkg::ST_IDLE:
            begin
                busy = 1'b0;
                if (in_fire)
                begin
                    cmd.load = 1'b1;
                    state_next = pnre_pkg::ST_SCAN;
                end
            end
            pnre_pkg::ST_SCAN:
            begin
                // The decode settles in this first busy cycle; the scan runs if needed.
                if (sts.op == pnre_pkg::OP_NONE)
                begin
                    state_next = pnre_pkg::ST_OUT;
                end
                else if (sts.scan_done)
                begin
                    cmd.rd_origin = 1'b1;
                    state_next = pnre_pkg::ST_READ;
                end
                else
                begin
                    cmd.scan_step = 1'b1;
                end
            end
            pnre_pkg::ST_READ:
            begin
                state_next = pnre_pkg::ST_WRITE;
            end
            pnre_pkg::ST_WRITE:
            begin
                cmd.wr_apply = 1'b1;
                state_next = pnre_pkg::ST_OUT;
            end
            pnre_pkg::ST_OUT:
            begin
                if (out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next = pnre_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = pnre_pkg::ST_IDLE;
            end
        endcase
        cmd.scan_start = cmd.load;
    end

endmodule

>>> rtl/core/pnre_dp.sv
`timescale 1ns / 1ps
module pnre_dp (
    input  logic                 clk,
    input  logic                 rst_n,
    input  pnre_pkg::pnre_cmd_t  cmd,
    output pnre_pkg::pnre_sts_t  sts,
    input  logic                 cfg_we,
    input  logic [1:0]           cfg_index,
    input  logic [31:0]          cfg_data,
    input  logic [162:0]         in_data,
    input  logic                 in_dir,
    output logic [130:0]         res_data
);

    localparam int N = pnre_pkg::TableEntries;
    localparam int IW = pnre_pkg::IdxW;
    localparam int CW = pnre_pkg::CntW;

    logic [31:0] bridge_ip_reg;
    logic [15:0] proxy_port_reg, dns_proxy_port_reg, dns_capture_port_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bridge_ip_reg <= '0;
            proxy_port_reg <= '0;
            dns_proxy_port_reg <= '0;
            dns_capture_port_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                pnre_pkg::CfgBridgeIp:       bridge_ip_reg <= cfg_data;
                pnre_pkg::CfgProxyPort:      proxy_port_reg <= cfg_data[15:0];
                pnre_pkg::CfgDnsProxyPort:   dns_proxy_port_reg <= cfg_data[15:0];
                pnre_pkg::CfgDnsCapturePort: dns_capture_port_reg <= cfg_data[15:0];
                default:                     bridge_ip_reg <= bridge_ip_reg;
            endcase
        end
    end

    // Captured packet fields.
    logic [162:0] pkt_reg;
    logic         dir_reg;
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            pkt_reg <= in_data;
            dir_reg <= in_dir;
        end
    end

    logic [15:0] etype, sport, dport, l4c, ipc;
    logic [2:0]  lstat;
    logic [7:0]  proto, flags;
    logic [31:0] sip, dip;
    logic        dir;
    assign etype = pkt_reg[15:0];
    assign lstat = pkt_reg[18:16];
    assign proto = pkt_reg[26:19];
    assign sip   = pkt_reg[58:27];
    assign dip   = pkt_reg[90:59];
    assign sport = pkt_reg[106:91];
    assign dport = pkt_reg[122:107];
    assign flags = pkt_reg[130:123];
    assign l4c   = pkt_reg[146:131];
    assign ipc   = pkt_reg[162:147];
    assign dir   = dir_reg;

    // Decode into five action flags plus the drop verdict.
    logic tcp, udp, l4ok, drop;
    logic a_svc_lk, a_dns_lk, a_svc_ins, a_svc_rw, a_dns_ins;
    always_comb
    begin
        tcp = proto == pnre_pkg::ProtoTcp;
        udp = proto == pnre_pkg::ProtoUdp;
        drop = (lstat > 3'd4) || (lstat == 3'd1)
            || (etype == pnre_pkg::EthTypeIpv4 && (lstat == 3'd2
                || (lstat == 3'd4 && (tcp || udp))));
        l4ok = etype == pnre_pkg::EthTypeIpv4 && lstat == 3'd0 && (tcp || udp);
        a_svc_lk = l4ok && !dir && tcp && sip == bridge_ip_reg
            && sport == proxy_port_reg;
        a_dns_lk = l4ok && !dir && udp && sport == dns_proxy_port_reg
            && sip == bridge_ip_reg;
        a_svc_rw = l4ok && dir && tcp && dip == bridge_ip_reg
            && dport != proxy_port_reg;
        a_svc_ins = a_svc_rw && flags[pnre_pkg::FlagSyn] && !flags[pnre_pkg::FlagAck];
        a_dns_ins = l4ok && dir && udp && dport == dns_capture_port_reg
            && dip != bridge_ip_reg;
    end

    logic use_dns;
    assign use_dns = a_dns_lk || a_dns_ins;

    logic [63:0] key_a;
    logic [31:0] key_p;
    logic [47:0] origin;
    always_comb
    begin
        if (dir)
        begin
            key_a = {bridge_ip_reg, sip};
            key_p = {(use_dns ? dns_proxy_port_reg : proxy_port_reg), sport};
        end
        else
        begin
            key_a = {sip, dip};
            key_p = {sport, dport};
        end
        origin = {dip, dport};
    end

    pnre_pkg::op_t op_sel;
    always_comb
    begin
        if (a_svc_lk || a_dns_lk)
            op_sel = pnre_pkg::OP_LOOKUP;
        else if (a_svc_ins || a_dns_ins)
            op_sel = pnre_pkg::OP_INSERT;
        else
            op_sel = pnre_pkg::OP_NONE;
    end
    assign sts.op = op_sel;

    // Tables: valid bits in flip-flops, keys and origins in memories.
    logic [N-1:0] svc_v_reg, dns_v_reg;
    logic [95:0]  svc_key_mem [N];
    logic [95:0]  dns_key_mem [N];
    logic [47:0]  svc_org_mem [N];
    logic [47:0]  dns_org_mem [N];

    logic [CW-1:0] scan_reg;
    logic [IW-1:0] hit_idx_reg, free_idx_reg;
    logic          hit_reg, free_reg;
    logic [95:0]   key_rd_reg;
    logic          key_rd_ok_reg;
    logic [IW-1:0] key_rd_idx_reg;
    logic [47:0]   org_rd_reg;

    logic [IW-1:0] scan_idx;
    assign scan_idx = scan_reg[IW-1:0];
    assign sts.scan_done = scan_reg == CW'(N) && !key_rd_ok_reg;

    // Scan: one entry read per cycle, compared in the cycle after its read.
    always_ff @(posedge clk)
    begin
        if (cmd.scan_step && scan_reg != CW'(N))
        begin
            key_rd_reg <= use_dns ? dns_key_mem[scan_idx] : svc_key_mem[scan_idx];
            key_rd_idx_reg <= scan_idx;
        end
        if (cmd.rd_origin)
        begin
            org_rd_reg <= use_dns ? dns_org_mem[hit_idx_reg] : svc_org_mem[hit_idx_reg];
        end
        if (cmd.wr_apply && op_sel == pnre_pkg::OP_INSERT && !hit_reg && free_reg)
        begin
            if (use_dns)
            begin
                dns_key_mem[free_idx_reg] <= {key_a, key_p};
                dns_org_mem[free_idx_reg] <= origin;
            end
            else
            begin
                svc_key_mem[free_idx_reg] <= {key_a, key_p};
                svc_org_mem[free_idx_reg] <= origin;
            end
        end
    end

    logic rd_valid;
    assign rd_valid = use_dns ? dns_v_reg[key_rd_idx_reg] : svc_v_reg[key_rd_idx_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scan_reg <= '0;
            key_rd_ok_reg <= 1'b0;
            hit_reg <= 1'b0;
            free_reg <= 1'b0;
            hit_idx_reg <= '0;
            free_idx_reg <= '0;
            svc_v_reg <= '0;
            dns_v_reg <= '0;
        end
        else
        begin
            if (cmd.scan_start)
            begin
                scan_reg <= '0;
                key_rd_ok_reg <= 1'b0;
                hit_reg <= 1'b0;
                free_reg <= 1'b0;
            end
            else if (cmd.scan_step)
            begin
                key_rd_ok_reg <= scan_reg != CW'(N);
                if (scan_reg != CW'(N))
                begin
                    scan_reg <= scan_reg + CW'(1);
                end
                if (key_rd_ok_reg)
                begin
                    if (rd_valid && key_rd_reg == {key_a, key_p} && !hit_reg)
                    begin
                        hit_reg <= 1'b1;
                        hit_idx_reg <= key_rd_idx_reg;
                    end
                    if (!rd_valid && !free_reg)
                    begin
                        free_reg <= 1'b1;
                        free_idx_reg <= key_rd_idx_reg;
                    end
                end
            end
            if (cmd.wr_apply)
            begin
                if (op_sel == pnre_pkg::OP_INSERT && !hit_reg && free_reg)
                begin
                    if (use_dns)
                        dns_v_reg[free_idx_reg] <= 1'b1;
                    else
                        svc_v_reg[free_idx_reg] <= 1'b1;
                end
                if (a_svc_lk && hit_reg && flags[pnre_pkg::FlagFin]
                    && flags[pnre_pkg::FlagAck])
                begin
                    svc_v_reg[hit_idx_reg] <= 1'b0;
                end
            end
        end
    end

    // Result assembly.
    logic [130:0] res_next;
    logic [130:0] res_reg;
    logic [15:0]  ol4, oipc, osport, odport;
    logic [31:0]  osip, odip;
    logic         rew, full;

    always_comb
    begin
        osip = sip;
        odip = dip;
        osport = sport;
        odport = dport;
        ol4 = l4c;
        oipc = ipc;
        rew = 1'b0;
        full = 1'b0;
        if (a_svc_lk && hit_reg)
        begin
            ol4 = pnre_pkg::csum_rep16(l4c, sport, org_rd_reg[15:0]);
            osport = org_rd_reg[15:0];
            rew = 1'b1;
        end
        else if (a_dns_lk && hit_reg)
        begin
            ol4 = pnre_pkg::csum_rep32(
                pnre_pkg::csum_rep16(l4c, sport, org_rd_reg[15:0]),
                sip, org_rd_reg[47:16]);
            oipc = pnre_pkg::csum_rep32(ipc, sip, org_rd_reg[47:16]);
            osip = org_rd_reg[47:16];
            osport = org_rd_reg[15:0];
            rew = 1'b1;
        end
        else if (a_svc_rw)
        begin
            full = a_svc_ins && !hit_reg && !free_reg;
            ol4 = pnre_pkg::csum_rep16(l4c, dport, proxy_port_reg);
            odport = proxy_port_reg;
            rew = 1'b1;
        end
        else if (a_dns_ins)
        begin
            full = !hit_reg && !free_reg;
            ol4 = pnre_pkg::csum_rep32(
                pnre_pkg::csum_rep16(l4c, dport, dns_proxy_port_reg),
                dip, bridge_ip_reg);
            oipc = pnre_pkg::csum_rep32(ipc, dip, bridge_ip_reg);
            odip = bridge_ip_reg;
            odport = dns_proxy_port_reg;
            rew = 1'b1;
        end
        res_next = {full, oipc, ol4, odport, osport, odip, osip, rew, drop};
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            res_reg <= res_next;
        end
    end

    assign res_data = res_reg;

endmodule

>>> rtl/core/proxy_nat_rewrite_engine_top.sv
`timescale 1ns / 1ps
// NAPT rewrite engine for a transparent local proxy. Each input beat carries
// the parsed header of one IPv4 packet; each output beat returns the verdict,
// rewritten addresses and ports, and RFC 1624 updated checksums. Packets are
// handled one at a time: a lookup or insert scans all 256 entries of the
// TCP or UDP table, one entry per cycle through a single memory read port.
// Such a packet goes through the scan (256 reads, the last compare and the
// issue of the origin read), then the read, table write and output load
// states before m_axis_tvalid rises; a packet that needs no table goes from
// the scan state straight to output load. s_axis_tready returns the cycle
// after the result is loaded, so a new packet is accepted only once the last
// is through, and a stalled receiver holds the engine until the previous
// result is taken. Both tables are empty after reset, with no clearing pass.
// Configuration is written through cfg_we/cfg_index/cfg_data; the user must
// write it only while the engine is idle, as the block does not enforce it.
module proxy_nat_rewrite_engine_top (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         cfg_we,
    input  logic [1:0]   cfg_index,
    input  logic [31:0]  cfg_data,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // ether_type, length_status, ip_protocol, src_ip, dst_ip, src_port,
    // dst_port, tcp_flags, l4_checksum, ip_checksum, then zero fill
    input  logic [167:0] s_axis_tdata,
    // direction
    input  logic         s_axis_tuser,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // verdict, rewritten, out_src_ip, out_dst_ip, out_src_port,
    // out_dst_port, out_l4_checksum, out_ip_checksum, table_full, zero fill
    output logic [135:0] m_axis_tdata
);

    pnre_pkg::pnre_cmd_t cmd;
    pnre_pkg::pnre_sts_t sts;
    logic busy, in_fire, out_free;
    logic [130:0] res;
    logic ov_reg;

    assign s_axis_tready = !busy;
    assign in_fire = s_axis_tvalid && s_axis_tready;
    assign out_free = !ov_reg || m_axis_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ov_reg <= 1'b0;
        else if (cmd.out_load)
            ov_reg <= 1'b1;
        else if (m_axis_tready)
            ov_reg <= 1'b0;
    end

    pnre_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n), .in_fire(in_fire), .out_free(out_free),
        .sts(sts), .cmd(cmd), .busy(busy)
    );

    // Header fields go over in tdata order, without the zero fill.
    pnre_dp u_dp (
        .clk(clk), .rst_n(rst_n), .cmd(cmd), .sts(sts),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .in_data(s_axis_tdata[162:0]), .in_dir(s_axis_tuser),
        .res_data(res)
    );

    assign m_axis_tvalid = ov_reg;
    assign m_axis_tdata = {5'b0, res};

endmodule

>>> test/tb_proxy_nat_rewrite_engine_top.sv
`timescale 1ns / 1ps
module tb_proxy_nat_rewrite_engine_top;

    // Direction carried in tuser.
    localparam bit DirIngress = 1'b0;
    localparam bit DirEgress  = 1'b1;

    // Length status codes as the parser reports them.
    typedef enum logic [2:0] {
        LEN_WHOLE,
        LEN_L2_SHORT,
        LEN_IP_SHORT,
        LEN_INNER_SHORT,
        LEN_L4_SHORT,
        LEN_BAD5,
        LEN_BAD6,
        LEN_BAD7
    } len_t;

    localparam int Tbl = pnre_pkg::TableEntries;
    localparam int TblSvc = 0;
    localparam int TblDns = 1;
    localparam int QuietLimit = 20000;
    localparam int DrainCycles = 300;

    typedef struct {
        bit          dir;
        logic [15:0] etype;
        logic [2:0]  lstat;
        logic [7:0]  proto;
        logic [31:0] sip;
        logic [31:0] dip;
        logic [15:0] sport;
        logic [15:0] dport;
        logic [7:0]  flags;
        logic [15:0] l4c;
        logic [15:0] ipc;
    } hdr_t;

    typedef struct {
        logic        drop;
        logic        rew;
        logic [31:0] sip;
        logic [31:0] dip;
        logic [15:0] sport;
        logic [15:0] dport;
        logic [15:0] l4c;
        logic [15:0] ipc;
        logic        full;
    } verdict_t;

    // RFC 1624 checksum updates with end-around carry.
    function automatic logic [15:0] fold_sum(logic [31:0] s);
        while (s >> 16)
            s = (s & 32'hFFFF) + (s >> 16);
        return ~s[15:0];
    endfunction

    function automatic logic [15:0] patch16(logic [15:0] hc, logic [15:0] was,
                                            logic [15:0] now);
        return fold_sum({16'b0, ~hc} + {16'b0, ~was} + {16'b0, now});
    endfunction

    function automatic logic [15:0] patch32(logic [15:0] hc, logic [31:0] was,
                                            logic [31:0] now);
        return fold_sum({16'b0, ~hc} + {16'b0, ~was[31:16]} + {16'b0, ~was[15:0]}
                        + {16'b0, now[31:16]} + {16'b0, now[15:0]});
    endfunction

    // Predicts the rewrite of each accepted header and keeps its own copy of
    // both connection tables; results are checked in order against it.
    class nat_scoreboard;
        logic [31:0] bridge;
        logic [15:0] proxy;
        logic [15:0] dns_proxy;
        logic [15:0] dns_capture;
        bit          used[2][Tbl];
        logic [63:0] key_addrs[2][Tbl];
        logic [31:0] key_ports[2][Tbl];
        logic [47:0] origin[2][Tbl];
        verdict_t    pending[$];
        int          errors;

        function void set_reg(logic [1:0] idx, logic [31:0] v);
            case (idx)
                pnre_pkg::CfgBridgeIp:       bridge = v;
                pnre_pkg::CfgProxyPort:      proxy = v[15:0];
                pnre_pkg::CfgDnsProxyPort:   dns_proxy = v[15:0];
                pnre_pkg::CfgDnsCapturePort: dns_capture = v[15:0];
                default: ;
            endcase
        endfunction

        function int find(int t, logic [63:0] a, logic [31:0] p);
            for (int i = 0; i < Tbl; i++)
                if (used[t][i] && key_addrs[t][i] == a && key_ports[t][i] == p)
                    return i;
            return -1;
        endfunction

        // Returns 1 when the key was new and no entry was free.
        function bit add(int t, logic [63:0] a, logic [31:0] p, logic [47:0] o);
            if (find(t, a, p) >= 0)
                return 0;
            for (int i = 0; i < Tbl; i++)
                if (!used[t][i])
                begin
                    used[t][i] = 1;
                    key_addrs[t][i] = a;
                    key_ports[t][i] = p;
                    origin[t][i] = o;
                    return 0;
                end
            return 1;
        endfunction

        function void note_header(hdr_t h);
            verdict_t r;
            bit tcp;
            bit udp;
            int i;
            tcp = (h.proto == pnre_pkg::ProtoTcp);
            udp = (h.proto == pnre_pkg::ProtoUdp);
            r = '{drop: 0, rew: 0, sip: h.sip, dip: h.dip, sport: h.sport,
                  dport: h.dport, l4c: h.l4c, ipc: h.ipc, full: 0};
            if (h.lstat > LEN_L4_SHORT || h.lstat == LEN_L2_SHORT)
                r.drop = 1;
            else if (h.etype != pnre_pkg::EthTypeIpv4)
                ;
            else if (h.lstat == LEN_IP_SHORT)
                r.drop = 1;
            else if (h.lstat == LEN_INNER_SHORT || (!tcp && !udp))
                ;
            else if (h.lstat == LEN_L4_SHORT)
                r.drop = 1;
            else if (h.dir == DirIngress && tcp)
            begin
                if (h.sip == bridge && h.sport == proxy)
                begin
                    i = find(TblSvc, {h.sip, h.dip}, {h.sport, h.dport});
                    if (i >= 0)
                    begin
                        if (h.flags[pnre_pkg::FlagFin] && h.flags[pnre_pkg::FlagAck])
                            used[TblSvc][i] = 0;
                        r.sport = origin[TblSvc][i][15:0];
                        r.l4c = patch16(h.l4c, h.sport, r.sport);
                        r.rew = 1;
                    end
                end
            end
            else if (h.dir == DirIngress)
            begin
                if (h.sport == dns_proxy && h.sip == bridge)
                begin
                    i = find(TblDns, {h.sip, h.dip}, {h.sport, h.dport});
                    if (i >= 0)
                    begin
                        r.sport = origin[TblDns][i][15:0];
                        r.sip = origin[TblDns][i][47:16];
                        r.l4c = patch32(patch16(h.l4c, h.sport, r.sport), h.sip, r.sip);
                        r.ipc = patch32(h.ipc, h.sip, r.sip);
                        r.rew = 1;
                    end
                end
            end
            else if (tcp)
            begin
                if (h.dip == bridge && h.dport != proxy)
                begin
                    // Only a bare SYN opens a connection record.
                    if (h.flags[pnre_pkg::FlagSyn] && !h.flags[pnre_pkg::FlagAck])
                        r.full = add(TblSvc, {bridge, h.sip}, {proxy, h.sport},
                                     {h.dip, h.dport});
                    r.dport = proxy;
                    r.l4c = patch16(h.l4c, h.dport, proxy);
                    r.rew = 1;
                end
            end
            else if (h.dport == dns_capture && h.dip != bridge)
            begin
                r.full = add(TblDns, {bridge, h.sip}, {dns_proxy, h.sport},
                             {h.dip, h.dport});
                r.dip = bridge;
                r.dport = dns_proxy;
                r.l4c = patch32(patch16(h.l4c, h.dport, dns_proxy), h.dip, bridge);
                r.ipc = patch32(h.ipc, h.dip, bridge);
                r.rew = 1;
            end
            pending.push_back(r);
        endfunction

        task report(string what, logic [31:0] got, logic [31:0] want);
            $display("%0t: %s got %h expected %h", $realtime, what, got, want);
            errors++;
        endtask

        task check_result(verdict_t g);
            verdict_t w;
            if (pending.size() == 0)
            begin
                report("unexpected result beat, verdict", {31'b0, g.drop}, 32'h0);
                return;
            end
            w = pending.pop_front();
            if (g.drop !== w.drop) report("verdict", {31'b0, g.drop}, {31'b0, w.drop});
            if (g.rew !== w.rew) report("rewritten", {31'b0, g.rew}, {31'b0, w.rew});
            if (g.sip !== w.sip) report("out_src_ip", g.sip, w.sip);
            if (g.dip !== w.dip) report("out_dst_ip", g.dip, w.dip);
            if (g.sport !== w.sport)
                report("out_src_port", {16'b0, g.sport}, {16'b0, w.sport});
            if (g.dport !== w.dport)
                report("out_dst_port", {16'b0, g.dport}, {16'b0, w.dport});
            if (g.l4c !== w.l4c)
                report("out_l4_checksum", {16'b0, g.l4c}, {16'b0, w.l4c});
            if (g.ipc !== w.ipc)
                report("out_ip_checksum", {16'b0, g.ipc}, {16'b0, w.ipc});
            if (g.full !== w.full) report("table_full", {31'b0, g.full}, {31'b0, w.full});
        endtask
    endclass

    logic         clk;
    logic         rst_n;
    logic         cfg_we;
    logic [1:0]   cfg_index;
    logic [31:0]  cfg_data;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [167:0] s_axis_tdata;
    logic         s_axis_tuser;
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [135:0] m_axis_tdata;

    proxy_nat_rewrite_engine_top uut (.*);

    nat_scoreboard sb = new();
    int send_idle_pct;
    int recv_stall_pct;
    int quiet;

    // Open connections the client side of the stimulus remembers, so that
    // replies and teardowns hit live table entries.
    logic [47:0] tcp_open[$];
    logic [47:0] dns_open[$];

    initial clk = 1'b0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // The receiver stalls at random; the chance is set per phase.
    always @(negedge clk)
        m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);

    // Both handshakes are sampled at the rising edge. Inputs are noted
    // before results are checked, though a result can never belong to the
    // beat accepted at the same edge.
    always @(posedge clk)
    begin
        hdr_t h;
        verdict_t g;
        if (rst_n && s_axis_tvalid && s_axis_tready)
        begin
            h.dir = s_axis_tuser;
            {h.ipc, h.l4c, h.flags, h.dport, h.sport, h.dip, h.sip, h.proto,
             h.lstat, h.etype} = s_axis_tdata[162:0];
            sb.note_header(h);
        end
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            {g.full, g.ipc, g.l4c, g.dport, g.sport, g.dip, g.sip, g.rew,
             g.drop} = m_axis_tdata[130:0];
            sb.check_result(g);
        end
    end

    // Watchdog: a run with no accepted beat for too long has hung.
    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet <= 0;
        else
            quiet <= quiet + 1;
        if (quiet >= QuietLimit)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    task automatic write_reg(logic [1:0] idx, logic [31:0] v);
        @(negedge clk);
        cfg_we = 1'b1;
        cfg_index = idx;
        cfg_data = v;
        sb.set_reg(idx, v);
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    // Drives one header beat and returns once it has been accepted. The
    // caller is at a falling edge; the task leaves at one too.
    task automatic send_header(hdr_t h);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_axis_tvalid = 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tuser = h.dir;
        s_axis_tdata = {5'b0, h.ipc, h.l4c, h.flags, h.dport, h.sport, h.dip, h.sip,
                        h.proto, h.lstat, h.etype};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        @(negedge clk);
        s_axis_tvalid = 1'b0;
    endtask

    function automatic hdr_t plain_header(bit dir, logic [7:0] proto);
        hdr_t h;
        h.dir = dir;
        h.etype = pnre_pkg::EthTypeIpv4;
        h.lstat = LEN_WHOLE;
        h.proto = proto;
        h.sip = $urandom;
        h.dip = $urandom;
        h.sport = 16'($urandom);
        h.dport = 16'($urandom);
        h.flags = 8'($urandom);
        h.l4c = 16'($urandom);
        h.ipc = 16'($urandom);
        return h;
    endfunction

    // Client SYN to the bridge; recorded so a reply can follow.
    function automatic hdr_t tcp_open_header();
        hdr_t h;
        h = plain_header(DirEgress, pnre_pkg::ProtoTcp);
        h.dip = sb.bridge;
        if (h.dport == sb.proxy)
            h.dport = h.dport + 16'd1;
        h.flags[pnre_pkg::FlagSyn] = 1'b1;
        h.flags[pnre_pkg::FlagAck] = ($urandom_range(9) == 0);
        tcp_open.push_back({h.sip, h.sport});
        return h;
    endfunction

    // Reply from the proxy toward a remembered client, sometimes a teardown.
    function automatic hdr_t tcp_reply_header(bit teardown);
        hdr_t h;
        int k;
        h = plain_header(DirIngress, pnre_pkg::ProtoTcp);
        h.sip = sb.bridge;
        h.sport = sb.proxy;
        if (tcp_open.size() > 0)
        begin
            k = $urandom_range(tcp_open.size() - 1);
            {h.dip, h.dport} = tcp_open[k];
            if (teardown)
                tcp_open.delete(k);
        end
        h.flags[pnre_pkg::FlagFin] = teardown;
        h.flags[pnre_pkg::FlagAck] = teardown | h.flags[pnre_pkg::FlagAck];
        return h;
    endfunction

    function automatic hdr_t dns_query_header();
        hdr_t h;
        h = plain_header(DirEgress, pnre_pkg::ProtoUdp);
        h.dport = sb.dns_capture;
        if (h.dip == sb.bridge)
            h.dip = h.dip ^ 32'h1;
        if ($urandom_range(9) == 0)
            h.l4c = 16'h0000;
        dns_open.push_back({h.sip, h.sport});
        return h;
    endfunction

    function automatic hdr_t dns_reply_header();
        hdr_t h;
        h = plain_header(DirIngress, pnre_pkg::ProtoUdp);
        h.sip = sb.bridge;
        h.sport = sb.dns_proxy;
        if (dns_open.size() > 0)
            {h.dip, h.dport} = dns_open[$urandom_range(dns_open.size() - 1)];
        return h;
    endfunction

    // Anything at all: bad lengths, other ether types and protocols.
    function automatic hdr_t noise_header();
        hdr_t h;
        h = plain_header(1'($urandom_range(1)), 8'($urandom));
        if ($urandom_range(1))
            h.proto = $urandom_range(1) ? pnre_pkg::ProtoTcp : pnre_pkg::ProtoUdp;
        if ($urandom_range(1))
            h.etype = 16'($urandom);
        h.lstat = 3'($urandom_range(7));
        if ($urandom_range(3) == 0)
            h.dip = sb.bridge;
        return h;
    endfunction

    function automatic hdr_t random_header();
        int pick;
        pick = $urandom_range(99);
        if (pick < 35) return tcp_open_header();
        if (pick < 55) return tcp_reply_header(1'b0);
        if (pick < 63) return tcp_reply_header(1'b1);
        if (pick < 78) return dns_query_header();
        if (pick < 88) return dns_reply_header();
        return noise_header();
    endfunction

    task automatic directed_headers();
        hdr_t h;
        // Every length code, including the undefined ones, on a TCP header.
        for (int c = 0; c < 8; c++)
        begin
            h = plain_header(DirEgress, pnre_pkg::ProtoTcp);
            h.dip = sb.bridge;
            h.lstat = 3'(c);
            send_header(h);
        end
        h = plain_header(DirEgress, pnre_pkg::ProtoTcp);
        h.etype = 16'hFFFF;
        h.lstat = LEN_IP_SHORT;
        send_header(h);
        h = plain_header(DirIngress, 8'hFF);
        send_header(h);
        // Open a connection, insert it twice, reply, tear it down, reply again.
        h = tcp_open_header();
        h.flags = 8'h02;
        h.sip = 32'hFFFF_FFFF;
        h.sport = 16'hFFFF;
        h.l4c = 16'hFFFF;
        tcp_open.delete();
        tcp_open.push_back({h.sip, h.sport});
        send_header(h);
        send_header(h);
        send_header(tcp_reply_header(1'b0));
        send_header(tcp_reply_header(1'b1));
        h = tcp_reply_header(1'b0);
        h.dip = 32'hFFFF_FFFF;
        h.dport = 16'hFFFF;
        send_header(h);
        // SYN with ACK is redirected but not recorded.
        h = tcp_open_header();
        h.flags = 8'h12;
        send_header(h);
        // Destination already the proxy port: left alone.
        h = plain_header(DirEgress, pnre_pkg::ProtoTcp);
        h.dip = sb.bridge;
        h.dport = sb.proxy;
        send_header(h);
        // DNS query with zero checksum, its reply, then one aimed at the bridge.
        h = dns_query_header();
        h.l4c = 16'h0000;
        h.ipc = 16'h0000;
        send_header(h);
        send_header(dns_reply_header());
        h = dns_query_header();
        h.dip = sb.bridge;
        send_header(h);
        h = noise_header();
        h.sip = 32'h0;
        h.dip = 32'h0;
        h.flags = 8'h00;
        send_header(h);
    endtask

    // Configuration is only written once every result is back.
    task automatic wait_idle();
        while (sb.pending.size() != 0)
            @(negedge clk);
        repeat (DrainCycles) @(negedge clk);
    endtask

    task automatic set_phase(int idle, int stall, logic [31:0] br, logic [15:0] pp,
                             logic [15:0] dp, logic [15:0] cp);
        wait_idle();
        send_idle_pct = idle;
        recv_stall_pct = stall;
        write_reg(pnre_pkg::CfgBridgeIp, br);
        write_reg(pnre_pkg::CfgProxyPort, {16'b0, pp});
        write_reg(pnre_pkg::CfgDnsProxyPort, {16'b0, dp});
        write_reg(pnre_pkg::CfgDnsCapturePort, {16'b0, cp});
        tcp_open.delete();
        dns_open.delete();
    endtask

    initial
    begin
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = 1'b0;
        m_axis_tready = 1'b0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        quiet = 0;
        sb.errors = 0;
        sb.set_reg(pnre_pkg::CfgBridgeIp, 32'h0);
        sb.set_reg(pnre_pkg::CfgProxyPort, 32'h0);
        sb.set_reg(pnre_pkg::CfgDnsProxyPort, 32'h0);
        sb.set_reg(pnre_pkg::CfgDnsCapturePort, 32'h0);
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Phase 1: all registers at zero, back to back, with the directed set.
        set_phase(0, 0, 32'h0, 16'h0, 16'h0, 16'h0);
        directed_headers();
        repeat (230) send_header(random_header());

        // Phase 2: all registers at their maximum.
        set_phase(55, 0, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        directed_headers();
        repeat (230) send_header(random_header());

        // Later phases: random settings and heavier back pressure. The tables
        // keep filling across phases, so inserts into full tables show up.
        set_phase(0, 55, $urandom, 16'($urandom), 16'($urandom), 16'h3500);
        repeat (250) send_header(random_header());
        set_phase(25, 25, $urandom, 16'($urandom), 16'($urandom), 16'($urandom));
        repeat (250) send_header(random_header());
        set_phase(int'($urandom_range(40)), int'($urandom_range(40)), $urandom,
                  16'($urandom), 16'($urandom), 16'($urandom));
        repeat (250) send_header(random_header());

        wait_idle();
        if (sb.errors == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

>>> proxy_nat_rewrite_engine_top.f
rtl/core/pnre_pkg.sv
rtl/core/pnre_ctrl.sv
rtl/core/pnre_dp.sv
rtl/core/proxy_nat_rewrite_engine_top.sv
test/tb_proxy_nat_rewrite_engine_top.sv
